[rtl/core/josephus_elimination_order_macros.svh]
// Assertion macros for the Josephus elimination order block.
// Used by the port checker; each macro expects clk and arst_n in scope.
`ifndef JOSEPHUS_ELIMINATION_ORDER_MACROS_SVH
`define JOSEPHUS_ELIMINATION_ORDER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define JEO_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define JEO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/jeo_pkg.sv]
// Shared types and constants for the Josephus elimination order block.
// No dependencies; imported by the ring cell, the top level and the port checker.
`default_nettype none

package jeo_pkg;

	localparam int PERSON_W = 7;
	localparam int CFG_W    = 7;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_CIRCLE_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 2'd1;

	localparam logic [CFG_W-1:0] CIRCLE_SIZE_RESET = 7'd7;
	localparam logic [CFG_W-1:0] STEP_SIZE_RESET   = 7'd3;

	// Operation broadcast to every cell of the ring.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_ROTATE,
		CELL_SHIFT
	} cell_op_t;

endpackage

`default_nettype wire

[rtl/core/jeo_cell.sv]
// One position of the person ring: holds one person number.
// Depends on jeo_pkg for the cell operation type and person width.
`default_nettype none

module jeo_cell import jeo_pkg::*; #(
	parameter int CNT_W = 7,
	parameter int INDEX = 0
) (
	input  wire logic                clk,
	input  wire cell_op_t            op,
	input  wire logic [CNT_W-1:0]    count,
	input  wire logic [PERSON_W-1:0] next_val,
	input  wire logic [PERSON_W-1:0] head_val,
	output logic      [PERSON_W-1:0] value
);

	localparam logic [PERSON_W-1:0] LOAD_VAL = PERSON_W'((INDEX + 1) % (1 << PERSON_W));
	localparam logic [CNT_W-1:0]    TAIL_CNT = CNT_W'(INDEX + 1);

	logic [PERSON_W-1:0] value_q;
	logic                is_tail;

	// The last occupied position takes the front person on a rotation.
	assign is_tail = (count == TAIL_CNT);

	always_ff @(posedge clk) begin
		case (op)
			CELL_LOAD:   value_q <= LOAD_VAL;
			CELL_ROTATE: value_q <= is_tail ? head_val : next_val;
			CELL_SHIFT:  value_q <= next_val;
			default:     value_q <= value_q;
		endcase
	end

	assign value = value_q;

endmodule

`default_nettype wire

[rtl/core/josephus_elimination_order.sv]
// Josephus elimination order: a ring of shifting cells holds the people still in the circle.
// A request on a non-empty circle is accepted while idle; the sequencer then, with busy high,
// does K-1 rotation steps then one removal step (K = step_size, zero taken as one).
// A new request is taken only once the previous one is finished and the sequencer is idle again.
// A request that finds the circle empty is answered in the cycle after acceptance. The receiver cannot stall.
// Reset clears the count (empty circle) and loads circle_size 7, step_size 3.
`default_nettype none

module josephus_elimination_order import jeo_pkg::*; #(
	parameter int MAX_PEOPLE = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Request channel
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic                 restart,
	// Result channel
	output logic                      done,
	output logic      [PERSON_W-1:0]  person,
	output logic                      is_last,
	output logic                      exhausted,
	// Configuration write port
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam int CNT_W = $clog2(MAX_PEOPLE + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PEOPLE);

	// The sequencer is either waiting for a request or working through one.
	typedef enum logic {
		ST_IDLE,
		ST_ROTATE
	} state_t;

	state_t              state_q;
	logic [CFG_W-1:0]    circle_size_q;
	logic [CFG_W-1:0]    step_size_q;
	logic [CNT_W-1:0]    count_q;
	logic [CFG_W-1:0]    rot_q;
	logic                done_q;
	logic [PERSON_W-1:0] person_q;
	logic                is_last_q;
	logic                exhausted_q;

	logic                accept;
	logic [CNT_W-1:0]    load_cnt;
	logic [CNT_W-1:0]    eff_cnt;
	logic [CFG_W-1:0]    rot_init;
	cell_op_t            cell_op;
	logic [PERSON_W-1:0] cell_val [MAX_PEOPLE];

	assign accept = start && (state_q == ST_IDLE);

	// A restart loads at most MAX_PEOPLE people.
	assign load_cnt = (32'(circle_size_q) > MAX_PEOPLE) ? MAX_CNT : CNT_W'(circle_size_q);
	assign eff_cnt  = restart ? load_cnt : count_q;

	// K of zero behaves as K of one, so the rotation count is K-1 floored at zero.
	// Rotating K-1 places one at a time wraps around the ring by itself, so no
	// modulo by the remaining count is needed.
	assign rot_init = (step_size_q == '0) ? '0 : step_size_q - CFG_W'(1);

	// Ring operation for this cycle. Loading happens on the accepting edge so the
	// rotation starts on the next cycle with the fresh ring in place.
	always_comb begin
		cell_op = CELL_HOLD;
		case (state_q)
			ST_IDLE: begin
				if (accept && restart) begin
					cell_op = CELL_LOAD;
				end
			end
			ST_ROTATE: begin
				cell_op = (rot_q == '0) ? CELL_SHIFT : CELL_ROTATE;
			end
			default: cell_op = CELL_HOLD;
		endcase
	end

	// Ring of cells: each cell takes from its right-hand neighbour; the occupied
	// tail takes the front person while rotating.
	for (genvar i = 0; i < MAX_PEOPLE; i++) begin : g_ring
		logic [PERSON_W-1:0] nxt;
		if (i < MAX_PEOPLE - 1) begin : g_mid
			assign nxt = cell_val[i+1];
		end else begin : g_end
			assign nxt = cell_val[i];
		end
		jeo_cell #(
			.CNT_W (CNT_W),
			.INDEX (i)
		) u_cell (
			.clk      (clk),
			.op       (cell_op),
			.count    (count_q),
			.next_val (nxt),
			.head_val (cell_val[0]),
			.value    (cell_val[i])
		);
	end

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			circle_size_q <= CIRCLE_SIZE_RESET;
			step_size_q   <= STEP_SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CIRCLE_SIZE: circle_size_q <= cfg_data;
				REG_STEP_SIZE:   step_size_q   <= cfg_data;
				default:         ;
			endcase
		end
	end

	// Sequencer with its registered result outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rot_q       <= '0;
			done_q      <= 1'b0;
			person_q    <= '0;
			is_last_q   <= 1'b0;
			exhausted_q <= 1'b0;
		end else begin
			// A result is strobed for an empty-circle request or at the removal cycle.
			done_q <= (accept && (eff_cnt == '0)) ||
				((state_q == ST_ROTATE) && (rot_q == '0));
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= eff_cnt;
						if (eff_cnt == '0) begin
							// Empty circle: report it at once; the sequencer stays idle.
							person_q    <= '0;
							is_last_q   <= 1'b0;
							exhausted_q <= 1'b1;
						end else begin
							rot_q   <= rot_init;
							state_q <= ST_ROTATE;
						end
					end
				end
				ST_ROTATE: begin
					if (rot_q == '0) begin
						// The front person is removed while the ring closes up.
						person_q    <= cell_val[0];
						is_last_q   <= (count_q == CNT_W'(1));
						exhausted_q <= 1'b0;
						count_q     <= count_q - CNT_W'(1);
						state_q     <= ST_IDLE;
					end else begin
						rot_q <= rot_q - CFG_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign person    = person_q;
	assign is_last   = is_last_q;
	assign exhausted = exhausted_q;

endmodule

`default_nettype wire

[rtl/core/jeo_checker.sv]
// Port-level checker for the Josephus elimination order block, bound to the top level.
// Depends on jeo_pkg and the assertion macros header.
`default_nettype none
`include "josephus_elimination_order_macros.svh"

module jeo_checker import jeo_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 start,
	input wire logic                 busy,
	input wire logic                 done,
	input wire logic [PERSON_W-1:0]  person,
	input wire logic                 is_last,
	input wire logic                 exhausted
);

	// An accepted request either starts work or is answered as exhausted.
	`JEO_ASSERT_NEXT(a_accept_progress, start && !busy, busy || (done && exhausted), "request neither started nor answered")
	// A removal result always ends the work of its request.
	`JEO_ASSERT_NOW(a_removal_ends_work, done && !exhausted, $fell(busy), "removal result outside end of work")
	// The end of work always carries a result.
	`JEO_ASSERT_NOW(a_work_ends_with_result, $fell(busy), done, "work ended without a result")
	// An exhausted answer names nobody and cannot also be the last removal.
	`JEO_ASSERT_NOW(a_exhausted_clean, done && exhausted, (person == '0) && !is_last, "exhausted result carries a person")

endmodule

bind josephus_elimination_order jeo_checker u_jeo_checker (.*);

`default_nettype wire
